// File: hdl/stok_pkg.sv
// Shared types and constants for the source tokenizer.
// Holds the result record layout, record codes and character codes; no dependencies.
`timescale 1ns / 1ps

package stok_pkg;

    localparam int LINE_BITS_DEF  = 20;
    localparam int COL_BITS_DEF   = 16;
    localparam int DEPTH_BITS_DEF = 8;

    // Most results one character can cause.
    localparam int MAX_RES  = 4;
    localparam int RES_BITS = $clog2(MAX_RES);
    localparam int CNT_BITS = $clog2(MAX_RES + 1);

    localparam int OUT_LINE_W = 20;
    localparam int OUT_COL_W  = 16;

    // Record kinds
    localparam logic [1:0] K_PIECE = 2'd0;
    localparam logic [1:0] K_END   = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;

    // Token types
    localparam logic [1:0] T_IDENT = 2'd0;
    localparam logic [1:0] T_STR   = 2'd1;
    localparam logic [1:0] T_CHAR  = 2'd2;
    localparam logic [1:0] T_SYM   = 2'd3;

    // Error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_STR_OPEN  = 3'd0;
    localparam logic [2:0] E_CHR_OPEN  = 3'd1;
    localparam logic [2:0] E_BAD_ESC   = 3'd2;
    localparam logic [2:0] E_CHR_EMPTY = 3'd3;
    localparam logic [2:0] E_CHR_LONG  = 3'd4;
    localparam logic [2:0] E_UNKNOWN   = 3'd5;

    // Character codes
    localparam logic [15:0] C_TAB   = 16'h0009;
    localparam logic [15:0] C_LF    = 16'h000A;
    localparam logic [15:0] C_CR    = 16'h000D;
    localparam logic [15:0] C_SP    = 16'h0020;
    localparam logic [15:0] C_DQ    = 16'h0022;
    localparam logic [15:0] C_SQ    = 16'h0027;
    localparam logic [15:0] C_STAR  = 16'h002A;
    localparam logic [15:0] C_SLASH = 16'h002F;
    localparam logic [15:0] C_BSL   = 16'h005C;
    localparam logic [15:0] C_US    = 16'h005F;
    localparam logic [15:0] C_LC_N  = 16'h006E;
    localparam logic [15:0] C_LC_T  = 16'h0074;

    typedef struct packed {
        logic [1:0]            kind;
        logic [1:0]            ttype;
        logic [2:0]            err;
        logic [15:0]           value;
        logic [OUT_LINE_W-1:0] line;
        logic [OUT_COL_W-1:0]  cs;
        logic [OUT_COL_W-1:0]  ce;
    } t_rec;

    typedef struct packed {
        logic [CNT_BITS-1:0] cnt;
        t_rec [MAX_RES-1:0]  recs;
    } t_step_out;

endpackage

// File: hdl/source_tokenizer.sv
// Top level of the source tokenizer: stream ports and the result buffer.
// Depends on stok_pkg and stok_step.
`timescale 1ns / 1ps

// One source character is taken per cycle while the result register is empty
// or its last record is being taken. Each character yields zero to four
// records; they leave one per cycle from a four-entry result register while
// m_axis_tready is high, and the next character is taken in the same cycle as
// the previous one's last record. Records of one character end with tlast high.
module source_tokenizer #(
    parameter int LINE_BITS  = stok_pkg::LINE_BITS_DEF,
    parameter int COL_BITS   = stok_pkg::COL_BITS_DEF,
    parameter int DEPTH_BITS = stok_pkg::DEPTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ch
    input  logic        s_axis_tlast,   // end_of_source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] error_code, [18:3] value, [38:19] line_no, [54:39] col_start,
    // [70:55] col_end, [71] zero
    output logic [71:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // [1:0] rec_kind, [3:2] token_type
    output logic        m_axis_tlast    // last
);
    import stok_pkg::*;

    t_step_out           step;
    t_rec                r_buf [MAX_RES];
    logic [CNT_BITS-1:0] r_n;
    logic [RES_BITS-1:0] r_p;
    logic                s_acc, m_acc, m_last;
    t_rec                cur;

    assign m_last        = (CNT_BITS'(r_p) + 1'b1) == r_n;
    assign m_axis_tvalid = r_n != '0;
    assign m_acc         = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_n == '0) || (m_axis_tready && m_last);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    stok_step #(
        .LINE_BITS (LINE_BITS),
        .COL_BITS  (COL_BITS),
        .DEPTH_BITS(DEPTH_BITS)
    ) u_step (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_acc  (s_acc),
        .i_ch   (s_axis_tdata),
        .i_eos  (s_axis_tlast),
        .o_step (step)
    );

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_buf[i] <= step.recs[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
            r_p <= '0;
        end else if (s_acc) begin
            r_n <= step.cnt;
            r_p <= '0;
        end else if (m_acc) begin
            if (m_last) begin
                r_n <= '0;
                r_p <= '0;
            end else begin
                r_p <= r_p + 1'b1;
            end
        end
    end

    assign cur = r_buf[r_p];
    assign m_axis_tdata = {1'b0, cur.ce, cur.cs, cur.line, cur.value, cur.err};
    assign m_axis_tuser = {cur.ttype, cur.kind};
    assign m_axis_tlast = m_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_BITS'(MAX_RES))
        else $error("result count out of range");

    a_ptr_in_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CNT_BITS'(r_p) < r_n))
        else $error("read pointer beyond buffered results");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |-> (r_n == '0 || (m_acc && m_last)))
        else $error("item accepted over undelivered results");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_n == $past(step.cnt) && r_p == '0))
        else $error("result buffer not loaded");

endmodule

// File: hdl/stok_step.sv
// Lexer state and the per-character step that yields up to four records.
// Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_step #(
    parameter int LINE_BITS  = stok_pkg::LINE_BITS_DEF,
    parameter int COL_BITS   = stok_pkg::COL_BITS_DEF,
    parameter int DEPTH_BITS = stok_pkg::DEPTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [15:0]         i_ch,
    input  logic                i_eos,
    output stok_pkg::t_step_out o_step
);
    import stok_pkg::*;

    typedef enum logic [3:0] {
        M_NORMAL, M_SLASH, M_LINEC, M_BLOCK, M_BSTAR, M_BSLASH,
        M_IDENT, M_STR, M_STR_ESC, M_CHR, M_CHR_ESC
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [LINE_BITS-1:0]  r_line, n_line, r_tsl, n_tsl;
    logic [COL_BITS-1:0]   r_col, n_col, r_tsc, n_tsc;
    logic [DEPTH_BITS-1:0] r_dep, n_dep;
    logic [1:0]            r_cc, n_cc;
    logic [15:0]           r_cf, n_cf;

    function automatic t_rec mk(logic [1:0] kind, logic [1:0] ttype, logic [2:0] err,
                                logic [15:0] value, logic [LINE_BITS-1:0] line,
                                logic [COL_BITS-1:0] cs, logic [COL_BITS-1:0] ce);
        t_rec r;
        r.kind  = kind;
        r.ttype = ttype;
        r.err   = err;
        r.value = value;
        r.line  = OUT_LINE_W'(line);
        r.cs    = OUT_COL_W'(cs);
        r.ce    = OUT_COL_W'(ce);
        return r;
    endfunction

    function automatic logic is_alpha(logic [15:0] c);
        return (c >= 16'h61 && c <= 16'h7A) || (c >= 16'h41 && c <= 16'h5A);
    endfunction

    function automatic logic is_num(logic [15:0] c);
        return c >= 16'h30 && c <= 16'h39;
    endfunction

    function automatic logic is_sym(logic [15:0] c);
        logic r;
        case (c)
            16'h28, 16'h29, 16'h5B, 16'h5D, 16'h7B, 16'h7D, 16'h7E, 16'h21,
            16'h25, 16'h5E, 16'h26, 16'h2A, 16'h2D, 16'h2B, 16'h3D, 16'h2F,
            16'h2C, 16'h2E, 16'h3F, 16'h3B, 16'h3A, 16'h7C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    logic [COL_BITS-1:0] cn;
    logic [COL_BITS-1:0] cl;

    always_comb begin
        logic [CNT_BITS-1:0] k;
        t_rec [MAX_RES-1:0]  res;
        logic                do_norm, do_block, do_lit, do_add, do_close, is_chr;
        logic [15:0]         addv;
        logic [COL_BITS-1:0] ce_close;
        logic [15:0]         c;

        c = i_ch;
        k = '0;
        res = '0;
        do_norm = 1'b0;
        do_block = 1'b0;
        do_lit = 1'b0;
        do_add = 1'b0;
        do_close = 1'b0;
        is_chr = 1'b0;
        addv = '0;
        ce_close = '0;
        n_mode = r_mode;
        n_line = r_line;
        n_col = r_col;
        n_tsl = r_tsl;
        n_tsc = r_tsc;
        n_dep = r_dep;
        n_cc = r_cc;
        n_cf = r_cf;
        cl = r_col;
        cn = (r_col != '1) ? r_col + 1'b1 : r_col;

        if (c != C_CR) begin
            unique case (r_mode)
                M_SLASH: begin
                    if (c == C_SLASH) begin
                        n_mode = M_LINEC;
                    end else if (c == C_STAR) begin
                        n_mode = M_BLOCK;
                        n_dep = DEPTH_BITS'(1);
                    end else begin
                        res[k[RES_BITS-1:0]] = mk(K_END, T_SYM, E_NONE, C_SLASH,
                                                  r_tsl, r_tsc, cl);
                        k = k + 1'b1;
                        do_norm = 1'b1;
                    end
                end
                M_LINEC: begin
                    if (c == C_LF) do_norm = 1'b1;
                end
                M_BLOCK: do_block = 1'b1;
                M_BSTAR: begin
                    if (c == C_SLASH) begin
                        if (r_dep != '0) n_dep = r_dep - 1'b1;
                        n_mode = (n_dep == '0) ? M_NORMAL : M_BLOCK;
                    end else begin
                        do_block = 1'b1;
                    end
                end
                M_BSLASH: begin
                    if (c == C_STAR) begin
                        if (r_dep != '1) n_dep = r_dep + 1'b1;
                        n_mode = M_BLOCK;
                    end else begin
                        do_block = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_num(c) || c == C_US) begin
                        res[k[RES_BITS-1:0]] = mk(K_PIECE, T_IDENT, E_NONE, c,
                                                  r_tsl, r_tsc, cn);
                        k = k + 1'b1;
                    end else begin
                        res[k[RES_BITS-1:0]] = mk(K_END, T_IDENT, E_NONE, '0,
                                                  r_tsl, r_tsc, cl);
                        k = k + 1'b1;
                        do_norm = 1'b1;
                    end
                end
                M_STR, M_CHR: do_lit = 1'b1;
                M_STR_ESC, M_CHR_ESC: begin
                    n_mode = (r_mode == M_CHR_ESC) ? M_CHR : M_STR;
                    if (c == C_LC_T) begin
                        do_add = 1'b1;
                        addv = C_TAB;
                    end else if (c == C_LC_N) begin
                        do_add = 1'b1;
                        addv = C_LF;
                    end else if (c == C_BSL || c == C_SQ || c == C_DQ) begin
                        do_add = 1'b1;
                        addv = c;
                    end else begin
                        // bad escape: flag the backslash, then treat c as plain
                        res[k[RES_BITS-1:0]] = mk(K_ERROR, T_IDENT, E_BAD_ESC, '0, r_line,
                                                  (cl > COL_BITS'(1)) ? cl - 1'b1
                                                                      : COL_BITS'(1),
                                                  cl);
                        k = k + 1'b1;
                        do_lit = 1'b1;
                    end
                end
                default: do_norm = 1'b1;
            endcase

            if (do_block) begin
                n_mode = M_BLOCK;
                if (c == C_STAR) begin
                    n_mode = M_BSTAR;
                end else if (c == C_SLASH) begin
                    n_mode = M_BSLASH;
                end else if (c == C_LF) begin
                    if (r_line != '1) n_line = r_line + 1'b1;
                    n_col = COL_BITS'(1);
                end
            end

            if (do_lit) begin
                is_chr = (n_mode == M_CHR);
                if (c == C_BSL) begin
                    n_mode = is_chr ? M_CHR_ESC : M_STR_ESC;
                end else if (c == C_LF) begin
                    res[k[RES_BITS-1:0]] = mk(K_ERROR, T_IDENT,
                                              is_chr ? E_CHR_OPEN : E_STR_OPEN, '0,
                                              r_tsl, r_tsc, cl);
                    k = k + 1'b1;
                    do_close = 1'b1;
                    ce_close = cl;
                    do_norm = 1'b1;
                end else if ((is_chr && c == C_SQ) || (!is_chr && c == C_DQ)) begin
                    do_close = 1'b1;
                    ce_close = cn;
                end else begin
                    do_add = 1'b1;
                    addv = c;
                end
            end

            if (do_add) begin
                if (n_mode == M_STR) begin
                    res[k[RES_BITS-1:0]] = mk(K_PIECE, T_STR, E_NONE, addv,
                                              r_tsl, r_tsc, cn);
                    k = k + 1'b1;
                end else begin
                    if (r_cc == 2'd0) n_cf = addv;
                    if (r_cc != 2'd2) n_cc = r_cc + 1'b1;
                end
            end

            if (do_close) begin
                if (is_chr) begin
                    if (n_cc == 2'd0) begin
                        res[k[RES_BITS-1:0]] = mk(K_ERROR, T_IDENT, E_CHR_EMPTY, '0,
                                                  r_tsl, r_tsc, ce_close);
                        k = k + 1'b1;
                    end else if (n_cc == 2'd2) begin
                        res[k[RES_BITS-1:0]] = mk(K_ERROR, T_IDENT, E_CHR_LONG, '0,
                                                  r_tsl, r_tsc, ce_close);
                        k = k + 1'b1;
                    end
                    res[k[RES_BITS-1:0]] = mk(K_END, T_CHAR, E_NONE,
                                              (n_cc != 2'd0) ? n_cf : 16'h0000,
                                              r_tsl, r_tsc, ce_close);
                end else begin
                    res[k[RES_BITS-1:0]] = mk(K_END, T_STR, E_NONE, '0,
                                              r_tsl, r_tsc, ce_close);
                end
                k = k + 1'b1;
                n_mode = M_NORMAL;
            end

            if (do_norm) begin
                n_mode = M_NORMAL;
                if (c == C_LF) begin
                    if (r_line != '1) n_line = r_line + 1'b1;
                    n_col = COL_BITS'(1);
                end else if (c == C_SP || c == C_TAB || is_num(c)) begin
                    n_mode = M_NORMAL;
                end else if (c == C_SLASH) begin
                    n_tsc = cl;
                    n_tsl = r_line;
                    n_mode = M_SLASH;
                end else if (is_alpha(c)) begin
                    n_tsc = cl;
                    n_tsl = r_line;
                    n_mode = M_IDENT;
                    res[k[RES_BITS-1:0]] = mk(K_PIECE, T_IDENT, E_NONE, c,
                                              r_line, cl, cn);
                    k = k + 1'b1;
                end else if (c == C_DQ) begin
                    n_tsc = cl;
                    n_tsl = r_line;
                    n_mode = M_STR;
                end else if (c == C_SQ) begin
                    n_tsc = cl;
                    n_tsl = r_line;
                    n_mode = M_CHR;
                    n_cc = 2'd0;
                    n_cf = '0;
                end else if (is_sym(c)) begin
                    res[k[RES_BITS-1:0]] = mk(K_END, T_SYM, E_NONE, c, r_line, cl, cn);
                    k = k + 1'b1;
                end else begin
                    res[k[RES_BITS-1:0]] = mk(K_ERROR, T_IDENT, E_UNKNOWN, '0,
                                              r_line, cl, cn);
                    k = k + 1'b1;
                end
            end

            if (c != C_LF) n_col = cn;
        end

        if (i_eos) begin
            is_chr = (n_mode == M_CHR || n_mode == M_CHR_ESC);
            case (n_mode)
                M_IDENT: begin
                    res[k[RES_BITS-1:0]] = mk(K_END, T_IDENT, E_NONE, '0,
                                              n_tsl, n_tsc, n_col);
                    k = k + 1'b1;
                end
                M_SLASH: begin
                    res[k[RES_BITS-1:0]] = mk(K_END, T_SYM, E_NONE, C_SLASH,
                                              n_tsl, n_tsc, n_col);
                    k = k + 1'b1;
                end
                M_STR, M_STR_ESC, M_CHR, M_CHR_ESC: begin
                    res[k[RES_BITS-1:0]] = mk(K_ERROR, T_IDENT,
                                              is_chr ? E_CHR_OPEN : E_STR_OPEN, '0,
                                              n_tsl, n_tsc, n_col);
                    k = k + 1'b1;
                    if (is_chr) begin
                        if (n_cc == 2'd0) begin
                            res[k[RES_BITS-1:0]] = mk(K_ERROR, T_IDENT, E_CHR_EMPTY, '0,
                                                      n_tsl, n_tsc, n_col);
                            k = k + 1'b1;
                        end else if (n_cc == 2'd2) begin
                            res[k[RES_BITS-1:0]] = mk(K_ERROR, T_IDENT, E_CHR_LONG, '0,
                                                      n_tsl, n_tsc, n_col);
                            k = k + 1'b1;
                        end
                        res[k[RES_BITS-1:0]] = mk(K_END, T_CHAR, E_NONE,
                                                  (n_cc != 2'd0) ? n_cf : 16'h0000,
                                                  n_tsl, n_tsc, n_col);
                    end else begin
                        res[k[RES_BITS-1:0]] = mk(K_END, T_STR, E_NONE, '0,
                                                  n_tsl, n_tsc, n_col);
                    end
                    k = k + 1'b1;
                end
                default: ;
            endcase
            // start the next source from reset
            n_mode = M_NORMAL;
            n_line = LINE_BITS'(1);
            n_col = COL_BITS'(1);
            n_tsc = '0;
            n_tsl = LINE_BITS'(1);
            n_dep = '0;
            n_cc = 2'd0;
            n_cf = '0;
        end

        o_step.cnt = k;
        o_step.recs = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_line <= LINE_BITS'(1);
            r_col  <= COL_BITS'(1);
            r_tsc  <= '0;
            r_tsl  <= LINE_BITS'(1);
            r_dep  <= '0;
            r_cc   <= 2'd0;
            r_cf   <= '0;
        end else if (i_acc) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_tsc  <= n_tsc;
            r_tsl  <= n_tsl;
            r_dep  <= n_dep;
            r_cc   <= n_cc;
            r_cf   <= n_cf;
        end
    end

endmodule

// File: sim/tb_source_tokenizer.sv
// Testbench for the source tokenizer: drives character items, predicts records.
// Depends on stok_pkg and source_tokenizer.
`timescale 1ns / 1ps

module tb_source_tokenizer;
    import stok_pkg::*;

    typedef enum logic [3:0] {
        LX_NORMAL, LX_SLASH, LX_LINEC, LX_BLOCK, LX_BSTAR, LX_BSLASH,
        LX_IDENT, LX_STR, LX_STR_ESC, LX_CHR, LX_CHR_ESC
    } t_lex;

    typedef struct packed {
        t_rec rec;
        logic last;
    } t_exp_rec;

    localparam logic [19:0] LINE_MAX  = 20'hFFFFF;
    localparam logic [15:0] COL_MAX   = 16'hFFFF;
    localparam logic [7:0]  DEPTH_MAX = 8'hFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] ch
    logic        s_axis_tlast;   // end_of_source
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // err, value, line, col_start, col_end, zero
    logic [3:0]  m_axis_tuser;   // [1:0] rec_kind, [3:2] token_type
    logic        m_axis_tlast;

    source_tokenizer DUT (.*);

    // Predictor state
    t_lex        lx_mode;
    logic [19:0] lx_line, lx_tok_line;
    logic [15:0] lx_col, lx_tok_col, lx_chr_first;
    logic [7:0]  lx_depth;
    logic [1:0]  lx_chr_cnt;

    t_exp_rec    exp_recs[$];
    int          step_cnt;
    int          n_fail;
    int          n_items;
    int          n_recs;
    bit          idle_on;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic lex_reset();
        lx_mode = LX_NORMAL; lx_line = 1; lx_col = 1; lx_tok_col = 0; lx_tok_line = 1;
        lx_depth = 0; lx_chr_cnt = 0; lx_chr_first = 0;
    endtask

    task automatic push_rec(logic [1:0] k, logic [1:0] t, logic [2:0] e, logic [15:0] v,
                            logic [19:0] ln, logic [15:0] cs, logic [15:0] ce);
        t_exp_rec r;
        r.rec = '{kind: k, ttype: t, err: e, value: v, line: ln, cs: cs, ce: ce};
        r.last = 0;
        if (step_cnt < MAX_RES) begin
            exp_recs.insert(exp_recs.size(), r);
            step_cnt++;
        end
    endtask

    function automatic logic [15:0] col_after();
        return (lx_col < COL_MAX) ? lx_col + 16'd1 : COL_MAX;
    endfunction

    function automatic bit letter_code(logic [15:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit_code(logic [15:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit symbol_code(logic [15:0] c);
        case (c)
            "(", ")", "[", "]", "{", "}", "~", "!", "%", "^", "&", "*",
            "-", "+", "=", "/", ",", ".", "?", ";", ":", "|": return 1;
            default: return 0;
        endcase
    endfunction

    function automatic bit in_chr();
        return lx_mode == LX_CHR || lx_mode == LX_CHR_ESC;
    endfunction

    task automatic mark_tok();
        lx_tok_col = lx_col;
        lx_tok_line = lx_line;
    endtask

    task automatic close_literal(logic [15:0] ce);
        if (in_chr()) begin
            if (lx_chr_cnt == 0)
                push_rec(K_ERROR, T_IDENT, E_CHR_EMPTY, 0, lx_tok_line, lx_tok_col, ce);
            else if (lx_chr_cnt >= 2)
                push_rec(K_ERROR, T_IDENT, E_CHR_LONG, 0, lx_tok_line, lx_tok_col, ce);
            push_rec(K_END, T_CHAR, E_NONE, lx_chr_cnt != 0 ? lx_chr_first : 16'd0,
                     lx_tok_line, lx_tok_col, ce);
        end else begin
            push_rec(K_END, T_STR, E_NONE, 0, lx_tok_line, lx_tok_col, ce);
        end
        lx_mode = LX_NORMAL;
    endtask

    task automatic unclosed_literal(logic [15:0] ce);
        push_rec(K_ERROR, T_IDENT, in_chr() ? E_CHR_OPEN : E_STR_OPEN, 0,
                 lx_tok_line, lx_tok_col, ce);
        close_literal(ce);
    endtask

    task automatic next_line();
        if (lx_line < LINE_MAX) lx_line++;
        lx_col = 1;
    endtask

    task automatic scan_normal(logic [15:0] c);
        lx_mode = LX_NORMAL;
        if (c == C_LF) next_line();
        else if (c == C_SP || c == C_TAB || digit_code(c)) begin
        end else if (c == C_SLASH) begin
            mark_tok(); lx_mode = LX_SLASH;
        end else if (letter_code(c)) begin
            mark_tok(); lx_mode = LX_IDENT;
            push_rec(K_PIECE, T_IDENT, E_NONE, c, lx_tok_line, lx_tok_col, col_after());
        end else if (c == C_DQ) begin
            mark_tok(); lx_mode = LX_STR;
        end else if (c == C_SQ) begin
            mark_tok(); lx_mode = LX_CHR; lx_chr_cnt = 0; lx_chr_first = 0;
        end else if (symbol_code(c))
            push_rec(K_END, T_SYM, E_NONE, c, lx_line, lx_col, col_after());
        else
            push_rec(K_ERROR, T_IDENT, E_UNKNOWN, 0, lx_line, lx_col, col_after());
    endtask

    task automatic add_literal(logic [15:0] v);
        if (lx_mode == LX_STR)
            push_rec(K_PIECE, T_STR, E_NONE, v, lx_tok_line, lx_tok_col, col_after());
        else begin
            if (lx_chr_cnt == 0) lx_chr_first = v;
            if (lx_chr_cnt < 2) lx_chr_cnt++;
        end
    endtask

    task automatic scan_literal(logic [15:0] c);
        bit chr;
        chr = lx_mode == LX_CHR;
        if (c == C_BSL) lx_mode = chr ? LX_CHR_ESC : LX_STR_ESC;
        else if (c == C_LF) begin
            unclosed_literal(lx_col);
            scan_normal(c);
        end else if ((chr && c == C_SQ) || (!chr && c == C_DQ))
            close_literal(col_after());
        else add_literal(c);
    endtask

    task automatic scan_escape(logic [15:0] c);
        logic [15:0] v;
        bit ok;
        ok = 1;
        lx_mode = (lx_mode == LX_CHR_ESC) ? LX_CHR : LX_STR;
        if (c == C_LC_T) v = C_TAB;
        else if (c == C_LC_N) v = C_LF;
        else if (c == C_BSL || c == C_SQ || c == C_DQ) v = c;
        else begin v = 0; ok = 0; end
        if (ok) add_literal(v);
        else begin
            push_rec(K_ERROR, T_IDENT, E_BAD_ESC, 0, lx_line,
                     lx_col > 1 ? lx_col - 16'd1 : 16'd1, lx_col);
            scan_literal(c);
        end
    endtask

    task automatic scan_block(logic [15:0] c);
        lx_mode = LX_BLOCK;
        if (c == C_STAR) lx_mode = LX_BSTAR;
        else if (c == C_SLASH) lx_mode = LX_BSLASH;
        else if (c == C_LF) next_line();
    endtask

    // Compute the records caused by one character and queue them.
    task automatic predict_records(logic [15:0] c, logic eos);
        int first;
        first = exp_recs.size();
        step_cnt = 0;
        if (c != C_CR) begin
            case (lx_mode)
                LX_SLASH:
                    if (c == C_SLASH) lx_mode = LX_LINEC;
                    else if (c == C_STAR) begin lx_mode = LX_BLOCK; lx_depth = 1; end
                    else begin
                        push_rec(K_END, T_SYM, E_NONE, C_SLASH, lx_tok_line, lx_tok_col,
                                 lx_col);
                        scan_normal(c);
                    end
                LX_LINEC: if (c == C_LF) scan_normal(c);
                LX_BLOCK: scan_block(c);
                LX_BSTAR:
                    if (c == C_SLASH) begin
                        if (lx_depth > 0) lx_depth--;
                        lx_mode = lx_depth == 0 ? LX_NORMAL : LX_BLOCK;
                    end else scan_block(c);
                LX_BSLASH:
                    if (c == C_STAR) begin
                        if (lx_depth < DEPTH_MAX) lx_depth++;
                        lx_mode = LX_BLOCK;
                    end else scan_block(c);
                LX_IDENT:
                    if (letter_code(c) || digit_code(c) || c == C_US)
                        push_rec(K_PIECE, T_IDENT, E_NONE, c, lx_tok_line, lx_tok_col,
                                 col_after());
                    else begin
                        push_rec(K_END, T_IDENT, E_NONE, 0, lx_tok_line, lx_tok_col, lx_col);
                        scan_normal(c);
                    end
                LX_STR, LX_CHR: scan_literal(c);
                LX_STR_ESC, LX_CHR_ESC: scan_escape(c);
                default: scan_normal(c);
            endcase
            if (c != C_LF) lx_col = col_after();
        end
        if (eos) begin
            case (lx_mode)
                LX_IDENT: push_rec(K_END, T_IDENT, E_NONE, 0, lx_tok_line, lx_tok_col, lx_col);
                LX_SLASH: push_rec(K_END, T_SYM, E_NONE, C_SLASH, lx_tok_line, lx_tok_col,
                                   lx_col);
                LX_STR, LX_STR_ESC, LX_CHR, LX_CHR_ESC: unclosed_literal(lx_col);
                default: ;
            endcase
            lex_reset();
        end
        if (exp_recs.size() > first) exp_recs[exp_recs.size() - 1].last = 1;
    endtask

    // Present one character and wait until it is taken; valid stays high
    // afterwards until the next item, an idle burst or the final drain replaces it.
    task automatic send_char(logic [15:0] c, logic eos = 0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_records(c, eos);
        n_items++;
    endtask

    task automatic send_text(string s, logic eos_at_end = 1);
        for (int i = 0; i < s.len(); i++)
            send_char(16'(s[i]), eos_at_end && i == s.len() - 1);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 0;
        while (exp_recs.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Check every record taken from the output.
    always @(posedge i_clk) begin
        t_exp_rec e;
        t_rec a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a = '{kind: m_axis_tuser[1:0], ttype: m_axis_tuser[3:2], err: m_axis_tdata[2:0],
                  value: m_axis_tdata[18:3], line: m_axis_tdata[38:19],
                  cs: m_axis_tdata[54:39], ce: m_axis_tdata[70:55]};
            n_recs++;
            if (exp_recs.size() == 0) begin
                $display("%0t: unexpected record %h last %b", $time, a, m_axis_tlast);
                n_fail++;
            end else begin
                e = exp_recs.pop_front();
                if (e.rec !== a || e.last !== m_axis_tlast || m_axis_tdata[71] !== 1'b0) begin
                    $display("%0t: mismatch exp %h/%b act %h/%b", $time, e.rec, e.last,
                             a, m_axis_tlast);
                    n_fail++;
                end
            end
        end
    end

    // Output stall: bursts of back pressure while idling is enabled.
    initial begin
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            m_axis_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (idle_on) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic test_tokens();
        send_text("ab_9 x\t(|)~;+/q\n", 0);
        send_text("@\r`#", 0);
        send_char(16'hFFFF);
        send_char(16'h0000, 1);
    endtask

    task automatic test_comments();
        send_text("a//c\"x\nb /* o /* i */ z */ 7/", 1);
        send_text("/*/*unclosed", 1);
        send_text("/", 1);
    endtask

    task automatic test_literals();
        send_text("\"a\\t\\n\\\\\\'\\\"\\q\"", 0);
        send_text("''", 0);
        send_text("'\\n'", 0);
        send_text("'ab'", 0);
        send_text("'x\n\"s\ny", 0);
        send_text("\"open\\", 1);
        send_text("'z", 1);
    endtask

    function automatic logic [15:0] rand_char();
        string pool;
        pool = "abzAZ_09 \t\n\r/*'\"\\tn(|)+;.";
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(32, 126));
            default: return 16'(pool[$urandom_range(0, pool.len() - 1)]);
        endcase
    endfunction

    task automatic test_random();
        for (int i = 0; i < 35; i++) begin
            if (i == 25) idle_on = 0;
            send_char(rand_char(), $urandom_range(0, 24) == 0);
        end
        send_char(C_SP, 1);
    endtask

    task automatic test_long_line();
        // Several lines of letters push column and line counters up.
        for (int i = 0; i < 30; i++) send_char(i % 10 == 0 ? C_LF : 16'("k"));
        send_char(16'("q"), 1);
    endtask

    initial begin
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
        i_rst_n = 0; n_fail = 0; n_items = 0; n_recs = 0; idle_on = 1;
        lex_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_tokens();
        test_comments();
        test_literals();
        test_long_line();
        test_random();
        wait_drained();
        $display("covered %0d characters, %0d records: tokens, comments, literals, escapes",
                 n_items, n_recs);
        if (n_fail == 0 && exp_recs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d records still expected", exp_recs.size());
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end
endmodule
